// ===== rtl/core/rrdb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrdb_pkg
// Shared types, codes and defaults of the rectangular day ring pixel
// generator.
// ----------------------------------------------------------------------------
package rrdb_pkg;

  localparam int COORD_BITS_DEF     = 10;
  localparam int BAR_THICKNESS_DEF  = 5;
  localparam int TICK_INNER_LEN_DEF = 4;
  localparam int TICK_WIDTH_DEF     = 2;

  localparam int MIN_BITS     = 11;
  localparam int IDX_BITS     = 12;
  localparam int CFG_IDX_BITS = 3;
  localparam int IN_DATA_W    = ((IDX_BITS + MIN_BITS + 7) / 8) * 8;

  localparam int MINUTES_PER_DAY = 1440;
  localparam int MAX_MINUTE      = 1439;

  localparam int RST_RECT_LEFT   = 1;
  localparam int RST_RECT_TOP    = 51;
  localparam int RST_RECT_RIGHT  = 198;
  localparam int RST_RECT_BOTTOM = 149;
  localparam int RST_WORK_START  = 540;
  localparam int RST_WORK_END    = 1260;
  localparam int RST_LUNCH_START = 720;
  localparam int RST_LUNCH_END   = 840;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RECT_LEFT   = 3'd0,
    REG_RECT_TOP    = 3'd1,
    REG_RECT_RIGHT  = 3'd2,
    REG_RECT_BOTTOM = 3'd3,
    REG_WORK_START  = 3'd4,
    REG_WORK_END    = 3'd5,
    REG_LUNCH_START = 3'd6,
    REG_LUNCH_END   = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NIGHT = 2'd0,
    KIND_WORK  = 2'd1,
    KIND_LUNCH = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  function automatic logic content_colour(input kind_t kind, input logic dash);
    logic col;
    case (kind)
      KIND_NIGHT: col = 1'b0;
      KIND_WORK:  col = 1'b1;
      KIND_LUNCH: col = dash;
      default:    col = 1'b0;
    endcase
    return col;
  endfunction

endpackage

// ===== rtl/core/rrdb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrdb_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// payload. The upper NB-QB dividend bits must be below the divisor.
// ----------------------------------------------------------------------------
module rrdb_div #(
  parameter int NB  = 23,
  parameter int QB  = 13,
  parameter int DB  = 12,
  parameter int PLW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NB-1:0]  dividend,
  input  logic [DB-1:0]  divisor,
  input  logic [PLW-1:0] payload,
  output logic           out_valid,
  output logic [QB-1:0]  quotient,
  output logic [DB-1:0]  remainder,
  output logic [PLW-1:0] out_payload
);

  logic [QB-1:0]  vld_r;
  logic [DB-1:0]  rem_r [QB];
  logic [QB-1:0]  low_r [QB];
  logic [QB-1:0]  quo_r [QB];
  logic [DB-1:0]  dsr_r [QB];
  logic [PLW-1:0] pl_r  [QB];

  logic [DB-1:0]  rem_nxt [QB];
  logic [QB-1:0]  low_nxt [QB];
  logic [QB-1:0]  quo_nxt [QB];
  logic [DB-1:0]  dsr_nxt [QB];
  logic [PLW-1:0] pl_nxt  [QB];

  always_comb begin
    logic [DB:0]    trial;
    logic [DB:0]    diff;
    logic [DB-1:0]  rp;
    logic [DB-1:0]  dp;
    logic [QB-1:0]  lp;
    logic [QB-1:0]  qp;
    logic [PLW-1:0] pp;
    logic           ge;
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        rp = DB'(dividend[NB-1:QB]);
        lp = dividend[QB-1:0];
        qp = '0;
        dp = divisor;
        pp = payload;
      end else begin
        rp = rem_r[k-1];
        lp = low_r[k-1];
        qp = quo_r[k-1];
        dp = dsr_r[k-1];
        pp = pl_r[k-1];
      end
      trial      = {rp, lp[QB-1]};
      diff       = trial - {1'b0, dp};
      ge         = (trial >= {1'b0, dp});
      rem_nxt[k] = ge ? diff[DB-1:0] : trial[DB-1:0];
      low_nxt[k] = {lp[QB-2:0], 1'b0};
      quo_nxt[k] = {qp[QB-2:0], ge};
      dsr_nxt[k] = dp;
      pl_nxt[k]  = pp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QB-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        quo_r[k] <= quo_nxt[k];
        dsr_r[k] <= dsr_nxt[k];
        pl_r[k]  <= pl_nxt[k];
      end
    end
  end

  assign out_valid   = vld_r[QB-1];
  assign quotient    = quo_r[QB-1];
  assign remainder   = rem_r[QB-1];
  assign out_payload = pl_r[QB-1];

endmodule

// ===== rtl/core/rect_ring_day_bar_pixels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_ring_day_bar_pixels
// Throughput: one pixel transaction per cycle while the output is not
//   stalled; a tick transaction holds the expander (and the input) until
//   all TICK_WIDTH * (BAR_THICKNESS + TICK_INNER_LEN) of its pixels issue.
// Reset: synchronous, active low; clears all valid bits and counters and
//   loads the register defaults. After a write, geometry settles once it
//   has passed through the first and second geometry levels.
// ----------------------------------------------------------------------------
module rect_ring_day_bar_pixels
  import rrdb_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int BAR_THICKNESS  = BAR_THICKNESS_DEF,
  parameter int TICK_INNER_LEN = TICK_INNER_LEN_DEF,
  parameter int TICK_WIDTH     = TICK_WIDTH_DEF,
  localparam int CFG_W    = (COORD_BITS > MIN_BITS) ? COORD_BITS : MIN_BITS,
  localparam int OUT_W    = ((2 * COORD_BITS + 3 + MIN_BITS + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_DATA_W-1:0]    in_tdata,   // perimeter_index, minute_now
  input  logic                    in_tuser,   // cmd
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_W-1:0]        out_tdata,  // pix_x, pix_y, inward_dir, colour,
                                              // minute_of_day
  output logic                    out_tlast,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  localparam int CB   = COORD_BITS;
  localparam int WB   = CB + 1;
  localparam int PB   = CB + 2;
  localparam int DB   = (PB > MIN_BITS) ? PB : MIN_BITS;
  localparam int SDB  = DB + 1;
  localparam int NB   = PB + MIN_BITS;
  localparam int QB   = PB + 1;
  localparam int VB   = (PB + 2 > 13) ? PB + 2 : 13;
  localparam int SVB  = VB + 1;
  localparam int GB   = VB + 1;
  localparam int TL   = BAR_THICKNESS + TICK_INNER_LEN;
  localparam int TB   = $clog2(TL);
  localparam int WCB  = (TICK_WIDTH > 1) ? $clog2(TICK_WIDTH) : 1;
  localparam int PL1  = 1 + MIN_BITS;
  localparam int PL2  = 2 + PB + MIN_BITS;

  // configuration registers
  logic [CB-1:0]       rect_left_r, rect_top_r, rect_right_r, rect_bottom_r;
  logic [MIN_BITS-1:0] work_start_r, work_end_r, lunch_start_r, lunch_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r   <= CB'(RST_RECT_LEFT);
      rect_top_r    <= CB'(RST_RECT_TOP);
      rect_right_r  <= CB'(RST_RECT_RIGHT);
      rect_bottom_r <= CB'(RST_RECT_BOTTOM);
      work_start_r  <= MIN_BITS'(RST_WORK_START);
      work_end_r    <= MIN_BITS'(RST_WORK_END);
      lunch_start_r <= MIN_BITS'(RST_LUNCH_START);
      lunch_end_r   <= MIN_BITS'(RST_LUNCH_END);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RECT_LEFT:   rect_left_r   <= cfg_wdata[CB-1:0];
        REG_RECT_TOP:    rect_top_r    <= cfg_wdata[CB-1:0];
        REG_RECT_RIGHT:  rect_right_r  <= cfg_wdata[CB-1:0];
        REG_RECT_BOTTOM: rect_bottom_r <= cfg_wdata[CB-1:0];
        REG_WORK_START:  work_start_r  <= cfg_wdata[MIN_BITS-1:0];
        REG_WORK_END:    work_end_r    <= cfg_wdata[MIN_BITS-1:0];
        REG_LUNCH_START: lunch_start_r <= cfg_wdata[MIN_BITS-1:0];
        REG_LUNCH_END:   lunch_end_r   <= cfg_wdata[MIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // geometry, first level: clamped width and height, lunch midpoint
  logic [CB+1:0]       dw, dh;
  logic [WB-1:0]       g1_w_r, g1_h_r;
  logic [CB-1:0]       g1_x0_r, g1_y0_r;
  logic [MIN_BITS-1:0] g1_lm_r;
  logic [MIN_BITS:0]   lsum;

  assign dw   = {2'b00, rect_right_r} - {2'b00, rect_left_r} + (CB+2)'(1);
  assign dh   = {2'b00, rect_bottom_r} - {2'b00, rect_top_r} + (CB+2)'(1);
  assign lsum = {1'b0, lunch_start_r} + {1'b0, lunch_end_r};

  always_ff @(posedge clk) begin
    g1_w_r  <= ($signed(dw) < $signed((CB+2)'(2))) ? WB'(2) : dw[WB-1:0];
    g1_h_r  <= ($signed(dh) < $signed((CB+2)'(2))) ? WB'(2) : dh[WB-1:0];
    g1_x0_r <= rect_left_r;
    g1_y0_r <= rect_top_r;
    g1_lm_r <= lsum[MIN_BITS:1];
  end

  // geometry, second level: perimeter, multiples, segment bounds
  logic [GB-1:0]       we, he, x0e, y0e;
  logic [PB-1:0]       g_p_r, g_th1_r, g_th2_r, g_th3_r;
  logic [VB-1:0]       g_p2_r, g_p3_r;
  logic [CB-1:0]       g_hw_r, g_x0_r, g_y0_r, g_x1_r, g_y1_r;
  logic [CB-1:0]       g_c1_r, g_c2_r, g_c3_r;
  logic [MIN_BITS-1:0] g_lm_r;

  assign we  = GB'(g1_w_r);
  assign he  = GB'(g1_h_r);
  assign x0e = GB'(g1_x0_r);
  assign y0e = GB'(g1_y0_r);

  always_ff @(posedge clk) begin
    g_p_r   <= PB'((we << 1) + (he << 1) - GB'(4));
    g_p2_r  <= VB'((we << 2) + (he << 2) - GB'(8));
    g_p3_r  <= VB'((we << 2) + (we << 1) + (he << 2) + (he << 1) - GB'(12));
    g_th1_r <= PB'(we);
    g_th2_r <= PB'(we + he - GB'(1));
    g_th3_r <= PB'((we << 1) + he - GB'(2));
    g_hw_r  <= CB'(g1_w_r >> 1);
    g_x0_r  <= g1_x0_r;
    g_y0_r  <= g1_y0_r;
    g_x1_r  <= CB'(x0e + we - GB'(1));
    g_y1_r  <= CB'(y0e + he - GB'(1));
    g_c1_r  <= CB'(y0e - we + GB'(1));
    g_c2_r  <= CB'(x0e + (we << 1) + he - GB'(3));
    g_c3_r  <= CB'(y0e + (we << 1) + (he << 1) - GB'(4));
    g_lm_r  <= g1_lm_r;
  end

  // handshake control
  logic en_f, en_b;
  logic x_valid_r, x_done;
  logic out_valid_r;

  assign en_b      = !out_valid_r || out_tready;
  assign en_f      = !x_valid_r || (en_b && x_done);
  assign in_tready = en_f;

  // S0 capture, S1 saturate
  logic                s0_valid_r, s1_valid_r;
  cmd_t                s0_cmd_r, s1_cmd_r;
  logic [IDX_BITS-1:0] s0_idx_r, s1_idx_r;
  logic [MIN_BITS-1:0] s0_now_r, s1_now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else if (en_f) begin
      s0_valid_r <= in_tvalid;
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      s0_cmd_r <= cmd_t'(in_tuser);
      s0_idx_r <= in_tdata[IDX_BITS-1:0];
      s0_now_r <= in_tdata[IDX_BITS+MIN_BITS-1:IDX_BITS];
      s1_cmd_r <= s0_cmd_r;
      s1_idx_r <= s0_idx_r;
      s1_now_r <= (s0_now_r > MIN_BITS'(MAX_MINUTE)) ? MIN_BITS'(MAX_MINUTE) : s0_now_r;
    end
  end

  // index modulo perimeter
  logic                d1_valid;
  logic [PB-1:0]       d1_rem;
  logic [PL1-1:0]      d1_pl;
  cmd_t                d1_cmd;
  logic [MIN_BITS-1:0] d1_now;

  rrdb_div #(
    .NB  (IDX_BITS + 1),
    .QB  (IDX_BITS),
    .DB  (PB),
    .PLW (PL1)
  ) u_mod_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en_f),
    .in_valid    (s1_valid_r),
    .dividend    ({1'b0, s1_idx_r}),
    .divisor     (g_p_r),
    .payload     ({s1_cmd_r, s1_now_r}),
    .out_valid   (d1_valid),
    .quotient    (),
    .remainder   (d1_rem),
    .out_payload (d1_pl)
  );

  assign d1_cmd = cmd_t'(d1_pl[PL1-1]);
  assign d1_now = d1_pl[MIN_BITS-1:0];

  // SA offset, SB product, SC magnitude
  logic                   sa_valid_r, sb_valid_r, sc_valid_r;
  cmd_t                   sa_cmd_r, sb_cmd_r, sc_cmd_r;
  logic [PB-1:0]          sa_p_r, sb_p_r, sc_p_r;
  logic [MIN_BITS-1:0]    sa_now_r, sb_now_r, sc_now_r;
  logic signed [SDB-1:0]  sa_sd_r;
  logic [DB-1:0]          sa_mb_r, sb_dsr_r, sc_dsr_r;
  logic signed [2*DB+1:0] prod_full;
  logic signed [NB:0]     sb_prod_r;
  logic [NB:0]            prod_neg;
  logic [NB-1:0]          sc_mag_r;
  logic                   sc_neg_r;

  assign prod_full = sa_sd_r * $signed({1'b0, sa_mb_r});
  assign prod_neg  = -sb_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
      sb_valid_r <= 1'b0;
      sc_valid_r <= 1'b0;
    end else if (en_f) begin
      sa_valid_r <= d1_valid;
      sb_valid_r <= sa_valid_r;
      sc_valid_r <= sb_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      sa_cmd_r <= d1_cmd;
      sa_p_r   <= d1_rem;
      sa_now_r <= d1_now;
      if (d1_cmd == CMD_PIXEL) begin
        sa_sd_r <= $signed(SDB'(d1_rem)) - $signed(SDB'(g_hw_r));
        sa_mb_r <= DB'(MINUTES_PER_DAY);
      end else begin
        sa_sd_r <= $signed(SDB'(d1_now)) - $signed(SDB'(g_lm_r));
        sa_mb_r <= DB'(g_p_r);
      end
      sb_cmd_r  <= sa_cmd_r;
      sb_p_r    <= sa_p_r;
      sb_now_r  <= sa_now_r;
      sb_prod_r <= prod_full[NB:0];
      sb_dsr_r  <= (sa_cmd_r == CMD_PIXEL) ? DB'(g_p_r) : DB'(MINUTES_PER_DAY);
      sc_cmd_r  <= sb_cmd_r;
      sc_p_r    <= sb_p_r;
      sc_now_r  <= sb_now_r;
      sc_dsr_r  <= sb_dsr_r;
      sc_neg_r  <= sb_prod_r[NB];
      sc_mag_r  <= sb_prod_r[NB] ? prod_neg[NB-1:0] : sb_prod_r[NB-1:0];
    end
  end

  // scaled quotient, truncated toward zero by sign and magnitude
  logic                d2_valid;
  logic [QB-1:0]       d2_q;
  logic [PL2-1:0]      d2_pl;
  cmd_t                d2_cmd;
  logic                d2_neg;
  logic [PB-1:0]       d2_p;
  logic [MIN_BITS-1:0] d2_now;

  rrdb_div #(
    .NB  (NB),
    .QB  (QB),
    .DB  (DB),
    .PLW (PL2)
  ) u_scale_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en_f),
    .in_valid    (sc_valid_r),
    .dividend    (sc_mag_r),
    .divisor     (sc_dsr_r),
    .payload     ({sc_cmd_r, sc_neg_r, sc_p_r, sc_now_r}),
    .out_valid   (d2_valid),
    .quotient    (d2_q),
    .remainder   (),
    .out_payload (d2_pl)
  );

  assign d2_cmd = cmd_t'(d2_pl[PL2-1]);
  assign d2_neg = d2_pl[PL2-2];
  assign d2_p   = d2_pl[PB+MIN_BITS-1:MIN_BITS];
  assign d2_now = d2_pl[MIN_BITS-1:0];

  // SE offset sum, SF wrap
  logic                  se_valid_r, sf_valid_r;
  cmd_t                  se_cmd_r, sf_cmd_r;
  logic [PB-1:0]         se_p_r, sf_p_r;
  logic [MIN_BITS-1:0]   se_now_r, sf_now_r;
  logic [VB-1:0]         se_v_r;
  logic signed [SVB-1:0] qs, v_nxt;
  logic [VB-1:0]         m1, m2, m3, wrap_nxt;
  logic [DB-1:0]         sf_res_r;

  always_comb begin
    qs = d2_neg ? -$signed(SVB'(d2_q)) : $signed(SVB'(d2_q));
    if (d2_cmd == CMD_PIXEL) begin
      v_nxt = qs + $signed(SVB'(g_lm_r)) + $signed(SVB'(MINUTES_PER_DAY));
    end else begin
      v_nxt = qs + $signed(SVB'(g_hw_r)) + $signed(SVB'(g_p2_r));
    end
  end

  always_comb begin
    if (se_cmd_r == CMD_PIXEL) begin
      m1 = VB'(MINUTES_PER_DAY);
      m2 = VB'(2 * MINUTES_PER_DAY);
      m3 = VB'(3 * MINUTES_PER_DAY);
    end else begin
      m1 = VB'(g_p_r);
      m2 = g_p2_r;
      m3 = g_p3_r;
    end
    if (se_v_r >= m3) begin
      wrap_nxt = se_v_r - m3;
    end else if (se_v_r >= m2) begin
      wrap_nxt = se_v_r - m2;
    end else if (se_v_r >= m1) begin
      wrap_nxt = se_v_r - m1;
    end else begin
      wrap_nxt = se_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      se_valid_r <= 1'b0;
      sf_valid_r <= 1'b0;
    end else if (en_f) begin
      se_valid_r <= d2_valid;
      sf_valid_r <= se_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      se_cmd_r <= d2_cmd;
      se_p_r   <= d2_p;
      se_now_r <= d2_now;
      se_v_r   <= VB'(v_nxt);
      sf_cmd_r <= se_cmd_r;
      sf_p_r   <= se_p_r;
      sf_now_r <= se_now_r;
      sf_res_r <= DB'(wrap_nxt);
    end
  end

  // X: expander holding one transaction, classify minute on load
  cmd_t                x_cmd_r;
  logic [PB-1:0]       x_idx_r;
  logic [MIN_BITS-1:0] x_min_r;
  kind_t               x_kind_r;
  logic [WCB-1:0]      x_w_r;
  logic [TB-1:0]       x_t_r;
  logic [MIN_BITS-1:0] sf_min;
  kind_t               kind_nxt;
  logic [PB:0]         x_sum;
  logic [PB-1:0]       x_i;

  assign sf_min = (sf_cmd_r == CMD_PIXEL) ? sf_res_r[MIN_BITS-1:0] : sf_now_r;

  always_comb begin
    if (sf_min < work_start_r || sf_min >= work_end_r) begin
      kind_nxt = KIND_NIGHT;
    end else if (sf_min >= lunch_start_r && sf_min < lunch_end_r) begin
      kind_nxt = KIND_LUNCH;
    end else begin
      kind_nxt = KIND_WORK;
    end
  end

  assign x_done = (x_cmd_r == CMD_PIXEL) ||
                  (x_w_r == WCB'(TICK_WIDTH - 1) && x_t_r == TB'(TL - 1));
  assign x_sum  = {1'b0, x_idx_r} + (PB+1)'(x_w_r);
  assign x_i    = (x_sum >= {1'b0, g_p_r}) ? PB'(x_sum - {1'b0, g_p_r}) : x_sum[PB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r <= 1'b0;
      x_w_r     <= '0;
      x_t_r     <= '0;
    end else if (en_f) begin
      x_valid_r <= sf_valid_r;
      x_w_r     <= '0;
      x_t_r     <= '0;
    end else if (en_b && x_valid_r) begin
      if (x_t_r == TB'(TL - 1)) begin
        x_t_r <= '0;
        x_w_r <= x_w_r + WCB'(1);
      end else begin
        x_t_r <= x_t_r + TB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      x_cmd_r  <= sf_cmd_r;
      x_idx_r  <= (sf_cmd_r == CMD_PIXEL) ? sf_p_r : PB'(sf_res_r);
      x_min_r  <= sf_min;
      x_kind_r <= kind_nxt;
    end
  end

  // L0 issue, L1 locate and colour, L2 step inward into output register
  logic                l0_valid_r, l1_valid_r;
  cmd_t                l0_cmd_r;
  logic [PB-1:0]       l0_idx_r;
  logic [TB-1:0]       l0_t_r, l1_t_r;
  kind_t               l0_kind_r;
  logic [MIN_BITS-1:0] l0_min_r, l1_min_r, out_min_r;
  logic                l0_last_r, l1_last_r, out_last_r;
  logic [CB-1:0]       l1_x_r, l1_y_r, out_x_r, out_y_r;
  dir_t                l1_dir_r, out_dir_r;
  logic                l1_col_r, out_col_r;
  logic [CB-1:0]       iw, loc_x, loc_y, tt, step_x, step_y;
  dir_t                loc_dir;
  logic                cc, col_nxt;

  assign iw = l0_idx_r[CB-1:0];

  always_comb begin
    if (l0_idx_r < g_th1_r) begin
      loc_x   = g_x0_r + iw;
      loc_y   = g_y0_r;
      loc_dir = DIR_DOWN;
    end else if (l0_idx_r < g_th2_r) begin
      loc_x   = g_x1_r;
      loc_y   = g_c1_r + iw;
      loc_dir = DIR_LEFT;
    end else if (l0_idx_r < g_th3_r) begin
      loc_x   = g_c2_r - iw;
      loc_y   = g_y1_r;
      loc_dir = DIR_UP;
    end else begin
      loc_x   = g_x0_r;
      loc_y   = g_c3_r - iw;
      loc_dir = DIR_RIGHT;
    end
  end

  always_comb begin
    cc = content_colour(l0_kind_r, l0_idx_r[1]);
    if (l0_cmd_r == CMD_PIXEL) begin
      col_nxt = cc;
    end else if ({1'b0, l0_t_r} >= (TB+1)'(BAR_THICKNESS)) begin
      col_nxt = 1'b1;
    end else if (l0_t_r == '0 || l0_t_r == TB'(BAR_THICKNESS - 1)) begin
      col_nxt = 1'b0;
    end else begin
      col_nxt = ~cc;
    end
  end

  assign tt = CB'(l1_t_r);

  always_comb begin
    step_x = l1_x_r;
    step_y = l1_y_r;
    case (l1_dir_r)
      DIR_DOWN:  step_y = l1_y_r + tt;
      DIR_LEFT:  step_x = l1_x_r - tt;
      DIR_UP:    step_y = l1_y_r - tt;
      DIR_RIGHT: step_x = l1_x_r + tt;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l0_valid_r  <= 1'b0;
      l1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en_b) begin
      l0_valid_r  <= x_valid_r;
      l1_valid_r  <= l0_valid_r;
      out_valid_r <= l1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      l0_cmd_r   <= x_cmd_r;
      l0_idx_r   <= x_i;
      l0_t_r     <= x_t_r;
      l0_kind_r  <= x_kind_r;
      l0_min_r   <= x_min_r;
      l0_last_r  <= x_done;
      l1_x_r     <= loc_x;
      l1_y_r     <= loc_y;
      l1_dir_r   <= loc_dir;
      l1_col_r   <= col_nxt;
      l1_t_r     <= l0_t_r;
      l1_min_r   <= l0_min_r;
      l1_last_r  <= l0_last_r;
      out_x_r    <= step_x;
      out_y_r    <= step_y;
      out_dir_r  <= l1_dir_r;
      out_col_r  <= l1_col_r;
      out_min_r  <= l1_min_r;
      out_last_r <= l1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_min_r, out_col_r, out_dir_r, out_y_r, out_x_r});
  assign out_tlast  = out_last_r;

endmodule
